// ===== sv/oate_pkg.sv =====
// ----------------------------------------------------------------------------
// oate_pkg
// Shared types and constants for the ordered array table engine.
// ----------------------------------------------------------------------------
package oate_pkg;

  localparam int CAPACITY   = 1024;
  localparam int WORD_BITS  = 32;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  localparam logic [3:0] OP_APPEND  = 4'd0;
  localparam logic [3:0] OP_READ    = 4'd1;
  localparam logic [3:0] OP_WRITE   = 4'd2;
  localparam logic [3:0] OP_INSERT  = 4'd3;
  localparam logic [3:0] OP_REMOVE  = 4'd4;
  localparam logic [3:0] OP_POPF    = 4'd5;
  localparam logic [3:0] OP_POPB    = 4'd6;
  localparam logic [3:0] OP_FIND    = 4'd7;
  localparam logic [3:0] OP_SWAP    = 4'd8;
  localparam logic [3:0] OP_SORT    = 4'd9;
  localparam logic [3:0] OP_BSEARCH = 4'd10;
  localparam logic [3:0] OP_REVERSE = 4'd11;
  localparam logic [3:0] OP_CLEAR   = 4'd12;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [WORD_BITS-1:0] word_out;
    logic                 hit;
    logic [IDX_BITS-1:0]  hit_index;
    logic [CNT_BITS-1:0]  count_now;
    logic [1:0]           status;
  } result_t;

  // Signed order key compare: a < b
  function automatic logic word_lt(logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== sv/oate_ram.sv =====
// ----------------------------------------------------------------------------
// oate_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module oate_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/ordered_array_table_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_table_engine
// Array table of signed words with count; sequenced commands on one RAM.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// s_axis  | in  | tvalid/tready      | tdata: opcode, position, other_position, word_in
// m_axis  | out | tvalid/tready      | tdata: word_out, hit, hit_index, count_now, status
// One command at a time through a single-port RAM (one access per cycle).
// Rejected or empty-walk commands go straight to done; append/write write once, read
// reads once, swap reads and writes both; insert/remove shift one entry at a time,
// find/bsearch read once per probe, reverse swaps pairs, sort swaps out-of-order pairs.
// Reset (rst, synchronous) empties the table; stored words are not cleared.
// A result waits in the output register; the next command is taken and runs
// while it waits, and stalls in its done state until the register drains.
// ----------------------------------------------------------------------------
module ordered_array_table_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] opcode, [13:4] position, [23:14] other_position, [55:24] word_in
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] word_out, [32] hit, [42:33] hit_index, [53:43] count_now,
  // [55:54] status
  output logic [55:0] m_axis_tdata
);

  localparam int IB = oate_pkg::IDX_BITS;
  localparam int CB = oate_pkg::CNT_BITS;
  localparam int WB = oate_pkg::WORD_BITS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD_A  = 9'b000000010,  // issue read at addr a
    S_WT_A  = 9'b000000100,  // data a back
    S_RD_B  = 9'b000001000,
    S_WT_B  = 9'b000010000,
    S_WR_A  = 9'b000100000,  // write at a
    S_WR_B  = 9'b001000000,
    S_STEP  = 9'b010000000,  // advance indices
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic [3:0]    op;
  logic [WB-1:0] val;
  logic [CB-1:0] count;
  logic [CB-1:0] ia, ib;        // walk indices
  logic signed [CB+1:0] lo, hi; // bsearch bounds
  logic [WB-1:0] da, db;        // captured words
  logic [WB-1:0] carry;         // write word for append/write; shifting word for insert
  oate_pkg::result_t res;
  logic          out_full;
  logic [55:0]   out_data;
  logic          out_load;

  logic [3:0]        in_op;
  logic [IB-1:0]     in_pos, in_pos2;
  logic [WB-1:0]     in_word;
  logic [1:0]        in_status;
  state_t            in_start;
  oate_pkg::result_t in_res;

  logic          ram_we;
  logic [IB-1:0] ram_addr;
  logic [WB-1:0] ram_wdata, ram_rdata;

  oate_ram #(.DEPTH(oate_pkg::CAPACITY), .WIDTH(WB)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign in_op   = s_axis_tdata[3:0];
  assign in_pos  = s_axis_tdata[13:4];
  assign in_pos2 = s_axis_tdata[23:14];
  assign in_word = s_axis_tdata[55:24];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = out_data;
  assign out_load      = (state == S_DONE) && (!out_full || m_axis_tready);

  logic signed [CB+1:0] mid;
  assign mid = (lo + hi) >>> 1;

  // Check an incoming command and pick its first state
  always_comb begin
    in_status = oate_pkg::ST_OK;
    in_start  = S_DONE;
    case (in_op)
      oate_pkg::OP_APPEND: begin
        if (count == CB'(oate_pkg::CAPACITY)) in_status = oate_pkg::ST_FULL;
        else in_start = S_WR_A;
      end
      oate_pkg::OP_READ, oate_pkg::OP_WRITE: begin
        if (CB'(in_pos) >= count) in_status = oate_pkg::ST_RANGE;
        else in_start = (in_op == oate_pkg::OP_WRITE) ? S_WR_A : S_RD_A;
      end
      oate_pkg::OP_REMOVE: begin
        if (count == '0) in_status = oate_pkg::ST_EMPTY;
        else if (CB'(in_pos) >= count) in_status = oate_pkg::ST_RANGE;
        else in_start = S_RD_A;
      end
      oate_pkg::OP_POPF, oate_pkg::OP_POPB: begin
        if (count == '0) in_status = oate_pkg::ST_EMPTY;
        else in_start = S_RD_A;
      end
      oate_pkg::OP_INSERT: begin
        if (count == CB'(oate_pkg::CAPACITY)) in_status = oate_pkg::ST_FULL;
        else if (CB'(in_pos) > count) in_status = oate_pkg::ST_RANGE;
        else if (CB'(in_pos) == count) in_start = S_WR_A;
        else in_start = S_RD_A;
      end
      oate_pkg::OP_FIND, oate_pkg::OP_BSEARCH: begin
        if (count != '0) in_start = S_RD_A;
      end
      oate_pkg::OP_SWAP: begin
        if (CB'(in_pos) >= count || CB'(in_pos2) >= count) in_status = oate_pkg::ST_RANGE;
        else in_start = S_RD_A;
      end
      oate_pkg::OP_SORT, oate_pkg::OP_REVERSE: begin
        if (count > CB'(1)) in_start = S_RD_A;
      end
      default: ;
    endcase
    in_res           = '0;
    in_res.count_now = (in_op == oate_pkg::OP_CLEAR) ? '0 : count;
    in_res.status    = in_status;
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ia[IB-1:0];
    ram_wdata = da;
    case (state)
      S_RD_A: ram_addr = (op == oate_pkg::OP_BSEARCH) ? mid[IB-1:0] : ia[IB-1:0];
      S_RD_B: ram_addr = ib[IB-1:0];
      S_WR_A: begin
        ram_we = 1'b1; ram_addr = ia[IB-1:0];
        ram_wdata = (op == oate_pkg::OP_INSERT || op == oate_pkg::OP_APPEND ||
                     op == oate_pkg::OP_WRITE) ? carry : db;
      end
      S_WR_B: begin
        ram_we = 1'b1; ram_addr = ib[IB-1:0]; ram_wdata = da;
      end
      default: ;
    endcase
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= in_op;
            val   <= in_word;
            res   <= in_res;
            state <= in_start;
            case (in_op)
              oate_pkg::OP_APPEND: begin
                ia <= count; carry <= in_word;
              end
              oate_pkg::OP_READ, oate_pkg::OP_REMOVE, oate_pkg::OP_WRITE,
              oate_pkg::OP_INSERT: begin
                ia <= CB'(in_pos); carry <= in_word;
              end
              oate_pkg::OP_POPF: ia <= '0;
              oate_pkg::OP_POPB: ia <= count - 1'b1;
              oate_pkg::OP_FIND: ia <= '0;
              oate_pkg::OP_SWAP: begin
                ia <= CB'(in_pos); ib <= CB'(in_pos2);
              end
              oate_pkg::OP_SORT: begin
                ia <= '0; ib <= CB'(1);
              end
              oate_pkg::OP_BSEARCH: begin
                lo <= '0; hi <= (CB+2)'(count) - 1'b1;
              end
              oate_pkg::OP_REVERSE: begin
                ia <= '0; ib <= count - 1'b1;
              end
              oate_pkg::OP_CLEAR: count <= '0;
              default: ;
            endcase
          end
        end
        S_RD_A: state <= S_WT_A;
        S_WT_A: begin
          da <= ram_rdata;
          case (op)
            oate_pkg::OP_READ: begin
              res.word_out <= ram_rdata; state <= S_DONE;
            end
            oate_pkg::OP_REMOVE, oate_pkg::OP_POPF, oate_pkg::OP_POPB: begin
              res.word_out <= ram_rdata;
              ib <= ia + 1'b1;
              if (ia + 1'b1 < count) state <= S_RD_B;
              else begin
                count <= count - 1'b1; res.count_now <= count - 1'b1; state <= S_DONE;
              end
            end
            oate_pkg::OP_INSERT: begin
              // write carry at ia, then move old word up
              state <= S_WR_A;
            end
            oate_pkg::OP_FIND: begin
              if (ram_rdata == val) begin
                res.hit <= 1'b1; res.hit_index <= ia[IB-1:0]; state <= S_DONE;
              end else if (ia + 1'b1 < count) begin
                ia <= ia + 1'b1; state <= S_RD_A;
              end else state <= S_DONE;
            end
            oate_pkg::OP_BSEARCH: begin
              if (ram_rdata == val) begin
                res.hit <= 1'b1; res.hit_index <= mid[IB-1:0]; state <= S_DONE;
              end else if (oate_pkg::word_lt(ram_rdata, val)) begin
                lo <= mid + 1'b1;
                state <= (mid < hi) ? S_RD_A : S_DONE;
              end else begin
                hi <= mid - 1'b1;
                state <= (lo < mid) ? S_RD_A : S_DONE;
              end
            end
            default: state <= S_RD_B; // swap, sort, reverse
          endcase
        end
        S_RD_B: state <= S_WT_B;
        S_WT_B: begin
          db <= ram_rdata;
          case (op)
            oate_pkg::OP_SORT:
              state <= oate_pkg::word_lt(ram_rdata, da) ? S_WR_A : S_STEP;
            oate_pkg::OP_REMOVE, oate_pkg::OP_POPF, oate_pkg::OP_POPB: state <= S_WR_A;
            default: state <= S_WR_A;
          endcase
        end
        S_WR_A: begin
          case (op)
            oate_pkg::OP_APPEND: begin
              count <= count + 1'b1; res.count_now <= count + 1'b1; state <= S_DONE;
            end
            oate_pkg::OP_INSERT: begin
              carry <= da;
              ia <= ia + 1'b1;
              if (ia < count) begin
                // last shifted word goes to count without a read
                state <= (ia + 1'b1 < count) ? S_RD_A : S_WR_A;
              end else begin
                count <= count + 1'b1; res.count_now <= count + 1'b1; state <= S_DONE;
              end
            end
            oate_pkg::OP_REMOVE, oate_pkg::OP_POPF, oate_pkg::OP_POPB: begin
              ia <= ib;
              if (ib + 1'b1 < count) begin
                ib <= ib + 1'b1; state <= S_RD_B;
              end else begin
                count <= count - 1'b1; res.count_now <= count - 1'b1; state <= S_DONE;
              end
            end
            oate_pkg::OP_WRITE: state <= S_DONE;
            default: state <= S_WR_B; // swap, sort, reverse
          endcase
        end
        S_WR_B: begin
          if (op == oate_pkg::OP_SORT) begin
            da <= db; state <= S_STEP;
          end else if (op == oate_pkg::OP_REVERSE) state <= S_STEP;
          else state <= S_DONE;
        end
        S_STEP: begin
          if (op == oate_pkg::OP_SORT) begin
            // da holds current entry i
            if (ib + 1'b1 < count) begin
              ib <= ib + 1'b1; state <= S_RD_B;
            end else if (ia + 2'd2 < count) begin
              ia <= ia + 1'b1; ib <= ia + 2'd2; state <= S_RD_A;
            end else state <= S_DONE;
          end else begin
            if (ia + 1'b1 < ib - 1'b1) begin
              ia <= ia + 1'b1; ib <= ib - 1'b1; state <= S_RD_A;
            end else state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
      out_data <= {res.status, res.count_now, res.hit_index, res.hit, res.word_out};
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // Count never exceeds capacity
  assert property (@(posedge clk) disable iff (rst) count <= CB'(oate_pkg::CAPACITY))
    else $error("count above capacity");
  // A result is raised only from the done state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> $past(state) == S_DONE)
    else $error("result without completion");
  // RAM writes happen only in the write states
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_WR_A || state == S_WR_B))
    else $error("stray ram write");
`endif

endmodule

// ===== tb/oate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oate_checker
// Watches both stream channels of the table engine, keeps its own copy of
// the table, predicts one result per accepted command and compares results
// field by field in order.
// ----------------------------------------------------------------------------
module oate_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  output int          mismatches,
  output int          outstanding,
  output int          table_fill
);

  logic signed [oate_pkg::WORD_BITS-1:0] shadow_table [oate_pkg::CAPACITY];
  int                                    shadow_count;
  oate_pkg::result_t                     pending_results [$];

  // Apply one command to the shadow table and return the result it gives
  function automatic oate_pkg::result_t apply_command(logic [55:0] cmd);
    logic [3:0]                            op;
    int                                    pos;
    int                                    pos2;
    logic signed [oate_pkg::WORD_BITS-1:0] w;
    logic signed [oate_pkg::WORD_BITS-1:0] t;
    oate_pkg::result_t                     r;
    int                                    lo;
    int                                    hi;
    int                                    mid;
    op   = cmd[3:0];
    pos  = int'(cmd[13:4]);
    pos2 = int'(cmd[23:14]);
    w    = cmd[55:24];
    r    = '0;
    case (op)
      oate_pkg::OP_APPEND: begin
        if (shadow_count >= oate_pkg::CAPACITY) r.status = oate_pkg::ST_FULL;
        else begin
          shadow_table[shadow_count] = w;
          shadow_count++;
        end
      end
      oate_pkg::OP_READ: begin
        if (pos >= shadow_count) r.status = oate_pkg::ST_RANGE;
        else r.word_out = shadow_table[pos];
      end
      oate_pkg::OP_WRITE: begin
        if (pos >= shadow_count) r.status = oate_pkg::ST_RANGE;
        else shadow_table[pos] = w;
      end
      oate_pkg::OP_INSERT: begin
        if (shadow_count >= oate_pkg::CAPACITY) r.status = oate_pkg::ST_FULL;
        else if (pos > shadow_count) r.status = oate_pkg::ST_RANGE;
        else begin
          for (int j = shadow_count; j > pos; j--) shadow_table[j] = shadow_table[j-1];
          shadow_table[pos] = w;
          shadow_count++;
        end
      end
      oate_pkg::OP_REMOVE, oate_pkg::OP_POPF, oate_pkg::OP_POPB: begin
        if (op == oate_pkg::OP_POPF) pos = 0;
        if (op == oate_pkg::OP_POPB) pos = shadow_count - 1;
        if (shadow_count == 0) r.status = oate_pkg::ST_EMPTY;
        else if (pos >= shadow_count) r.status = oate_pkg::ST_RANGE;
        else begin
          r.word_out = shadow_table[pos];
          for (int j = pos; j + 1 < shadow_count; j++) shadow_table[j] = shadow_table[j+1];
          shadow_count--;
        end
      end
      oate_pkg::OP_FIND: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_table[i] == w) begin
            r.hit       = 1'b1;
            r.hit_index = i[oate_pkg::IDX_BITS-1:0];
            break;
          end
        end
      end
      oate_pkg::OP_SWAP: begin
        if (pos >= shadow_count || pos2 >= shadow_count) r.status = oate_pkg::ST_RANGE;
        else begin
          t                  = shadow_table[pos];
          shadow_table[pos]  = shadow_table[pos2];
          shadow_table[pos2] = t;
        end
      end
      oate_pkg::OP_SORT: begin
        for (int i = 0; i < shadow_count; i++)
          for (int j = i + 1; j < shadow_count; j++)
            if (shadow_table[i] > shadow_table[j]) begin
              t               = shadow_table[i];
              shadow_table[i] = shadow_table[j];
              shadow_table[j] = t;
            end
      end
      oate_pkg::OP_BSEARCH: begin
        lo = 0;
        hi = shadow_count - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (shadow_table[mid] == w) begin
            r.hit       = 1'b1;
            r.hit_index = mid[oate_pkg::IDX_BITS-1:0];
            break;
          end
          if (shadow_table[mid] < w) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      oate_pkg::OP_REVERSE: begin
        for (int i = 0; i < shadow_count / 2; i++) begin
          t                                = shadow_table[i];
          shadow_table[i]                  = shadow_table[shadow_count-1-i];
          shadow_table[shadow_count-1-i]   = t;
        end
      end
      oate_pkg::OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.count_now = shadow_count[oate_pkg::CNT_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  // Check the oldest expectation first, then record the new command
  always @(posedge clk) begin
    oate_pkg::result_t want;
    if (rst) begin
      shadow_count = 0;
      pending_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== want.word_out)
            report_mismatch("word_out", m_axis_tdata[31:0], want.word_out);
          if (m_axis_tdata[32] !== want.hit)
            report_mismatch("hit", 32'(m_axis_tdata[32]), 32'(want.hit));
          if (m_axis_tdata[42:33] !== want.hit_index)
            report_mismatch("hit_index", 32'(m_axis_tdata[42:33]), 32'(want.hit_index));
          if (m_axis_tdata[53:43] !== want.count_now)
            report_mismatch("count_now", 32'(m_axis_tdata[53:43]), 32'(want.count_now));
          if (m_axis_tdata[55:54] !== want.status)
            report_mismatch("status", 32'(m_axis_tdata[55:54]), 32'(want.status));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(apply_command(s_axis_tdata));
    end
    outstanding <= pending_results.size();
    table_fill  <= shadow_count;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives commands into the ordered array table engine: a directed pass, then
// random traffic with random gaps and stalls on both sides. The checker
// predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS = 554;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [3:0] opcode, [13:4] position, [23:14] other_position, [55:24] word_in
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] word_out, [32] hit, [42:33] hit_index, [53:43] count_now,
  // [55:54] status
  logic [55:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int table_fill;
  bit no_gaps = 1'b0;
  bit long_hold_req = 1'b0;
  int idle_cycles = 0;

  ordered_array_table_engine dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  oate_checker u_checker (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .mismatches, .outstanding, .table_fill
  );

  initial forever #5 clk = ~clk;

  // Abort when no transaction happens on either side for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 13);
      if (long_hold_req && !held) begin
        stall = 400;
        held  = 1'b1;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Offer one command and hold it until accepted
  task automatic send_command(logic [3:0] op, int pos, int pos2, logic [31:0] w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {w, 10'(pos2), 10'(pos), op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      1, 2: return $urandom;
      default: return 32'($signed($urandom_range(0, 10)) - 5);
    endcase
  endfunction

  function automatic int pick_position();
    if ($urandom_range(0, 5) == 0) return int'($urandom_range(0, 1023));
    return int'($urandom_range(0, table_fill + 1));
  endfunction

  initial begin
    logic [3:0] op;
    bit         drained;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every command, empty and range errors
    send_command(oate_pkg::OP_POPF, 0, 0, 0);
    send_command(oate_pkg::OP_POPB, 0, 0, 0);
    send_command(oate_pkg::OP_REMOVE, 0, 0, 0);
    send_command(oate_pkg::OP_FIND, 0, 0, 0);
    send_command(oate_pkg::OP_BSEARCH, 0, 0, 0);
    send_command(oate_pkg::OP_APPEND, 0, 0, 32'h7fff_ffff);
    send_command(oate_pkg::OP_APPEND, 0, 0, 32'h8000_0000);
    send_command(oate_pkg::OP_APPEND, 0, 0, 32'hffff_ffff);
    send_command(oate_pkg::OP_INSERT, 3, 0, 32'd0);
    send_command(oate_pkg::OP_INSERT, 9, 0, 32'd5);
    send_command(oate_pkg::OP_READ, 1, 0, 0);
    send_command(oate_pkg::OP_READ, 1023, 0, 0);
    send_command(oate_pkg::OP_WRITE, 2, 0, 32'd7);
    send_command(oate_pkg::OP_WRITE, 4, 0, 32'd7);
    send_command(oate_pkg::OP_SWAP, 0, 3, 0);
    send_command(oate_pkg::OP_SWAP, 0, 1023, 0);
    send_command(oate_pkg::OP_FIND, 0, 0, 32'd7);
    send_command(oate_pkg::OP_SORT, 0, 0, 0);
    send_command(oate_pkg::OP_BSEARCH, 0, 0, 32'h8000_0000);
    send_command(oate_pkg::OP_BSEARCH, 0, 0, 32'd3);
    send_command(oate_pkg::OP_REVERSE, 0, 0, 0);
    send_command(oate_pkg::OP_REMOVE, 1, 0, 0);
    send_command(oate_pkg::OP_REMOVE, 5, 0, 0);
    send_command(4'd13, 0, 0, 0);
    send_command(4'd15, 0, 0, 0);
    send_command(oate_pkg::OP_CLEAR, 0, 0, 0);
    drain_results();

    // Random traffic with sorted-search sequences mixed in
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (n >= 250) long_hold_req = 1'b1;
      if (n >= 420 && !drained) begin
        drain_results();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) == 0 && table_fill <= 64) begin
        send_command(oate_pkg::OP_SORT, 0, 0, 0);
        repeat (3) send_command(oate_pkg::OP_BSEARCH, 0, 0, pick_word());
        n += 3;
      end else begin
        op = 4'($urandom_range(0, 15));
        if (table_fill < 10 && $urandom_range(0, 1) != 0) op = oate_pkg::OP_APPEND;
        if (op == oate_pkg::OP_SORT && table_fill > 64) op = oate_pkg::OP_REVERSE;
        if (table_fill > 80 && (op == oate_pkg::OP_APPEND || op == oate_pkg::OP_INSERT))
          op = oate_pkg::OP_POPB;
        if (op == oate_pkg::OP_CLEAR && $urandom_range(0, 3) != 0) op = oate_pkg::OP_FIND;
        send_command(op, pick_position(), pick_position(), pick_word());
      end
    end
    drain_results();

    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
